/* rtl/core/lcdns_pkg.sv */
`timescale 1ns / 1ps
// Package for the character LCD nibble sequencer.
// Holds request, job, event and configuration types, constants and the init table.
// No dependencies; every module of the block imports it.
package lcdns_pkg;

    // Display geometry and cursor address map.
    localparam int unsigned LINE_WIDTH = 20;
    localparam logic [7:0] POS_LINE1 = 8'(1 * LINE_WIDTH);
    localparam logic [7:0] POS_LINE2 = 8'(2 * LINE_WIDTH);
    localparam logic [7:0] POS_LINE3 = 8'(3 * LINE_WIDTH);
    localparam logic [7:0] POS_LIMIT = 8'(4 * LINE_WIDTH);
    localparam logic [7:0] BASE_LINE1 = 8'h40;
    localparam logic [7:0] BASE_LINE2 = 8'h14;
    localparam logic [7:0] BASE_LINE3 = 8'h54;

    // Command bytes and extra settle delays.
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic [4:0] EXTRA_NONE = 5'd0;
    localparam logic [4:0] EXTRA_CLEAR = 5'd2;
    localparam logic [5:0] HOLD_BASE_MS = 6'd1;
    localparam logic [5:0] HOLD_POWER_MS = 6'd50;

    // Queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

    // Configuration register indexes.
    localparam logic [1:0] CFG_FUNCTION = 2'd0;
    localparam logic [1:0] CFG_CONTROL = 2'd1;
    localparam logic [1:0] CFG_ENTRY = 2'd2;

    // Nibble index of the final init nibble (index 0 is the power-on wait).
    localparam logic [3:0] INIT_LAST_IDX = 4'd12;
    localparam logic [3:0] BYTE_LAST_IDX = 4'd1;

    // Enable pulse phases within one nibble.
    localparam logic [1:0] PH_LOW_A = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW_B = 2'd2;

    typedef enum logic [2:0] {
        REQ_INIT  = 3'd0,
        REQ_CMD   = 3'd1,
        REQ_DATA  = 3'd2,
        REQ_POS   = 3'd3,
        REQ_CLEAR = 3'd4
    } t_req_type;

    typedef enum logic {
        JOB_INIT = 1'b0,
        JOB_BYTE = 1'b1
    } t_job_kind;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] byte_value;
    } t_req;

    typedef struct packed {
        logic       reg_select;
        logic [3:0] data_nibble;
        logic       enable_level;
        logic [5:0] hold_ms;
        logic       last_event;
    } t_evt;

    typedef struct packed {
        logic [4:0] function_flags;
        logic [2:0] control_flags;
        logic [1:0] entry_flags;
    } t_cfg;

    typedef struct packed {
        t_job_kind  kind;
        logic       rs;
        logic [7:0] data;
        logic [4:0] extra;
    } t_job;

    // Data nibble of init step idx (1..12).
    function automatic logic [3:0] init_nibble(input logic [3:0] idx, input t_cfg cfg);
        logic [3:0] nib;
        unique case (idx) inside
            4'd1, 4'd2, 4'd3: nib = 4'h3;
            4'd4:             nib = 4'h2;
            4'd5:             nib = {3'b001, cfg.function_flags[4]};
            4'd6:             nib = cfg.function_flags[3:0];
            4'd7:             nib = 4'h0;
            4'd8:             nib = {1'b1, cfg.control_flags};
            4'd9:             nib = 4'h0;
            4'd10:            nib = 4'h1;
            4'd11:            nib = 4'h0;
            4'd12:            nib = {2'b01, cfg.entry_flags};
            default:          nib = 4'h0;
        endcase
        return nib;
    endfunction

    // Extra delay added to the last hold of init step idx.
    function automatic logic [4:0] init_extra(input logic [3:0] idx);
        logic [4:0] ext;
        unique case (idx) inside
            4'd1, 4'd2, 4'd4, 4'd6, 4'd8: ext = 5'd5;
            4'd3:                         ext = 5'd1;
            4'd10:                        ext = 5'd2;
            4'd12:                        ext = 5'd20;
            default:                      ext = 5'd0;
        endcase
        return ext;
    endfunction

endpackage

/* rtl/core/lcdns_front.sv */
`timescale 1ns / 1ps
// Front end: classifies a request beat into a sequencer job.
// Depends on lcdns_pkg.
module lcdns_front (
    input  lcdns_pkg::t_req i_req,
    input  logic            i_accept,
    output logic            o_push,
    output lcdns_pkg::t_job o_job
);
    import lcdns_pkg::*;

    logic [7:0] w_val;
    logic [7:0] w_addr;
    logic       w_keep;

    assign w_val = i_req.byte_value;

    // Map a linear cursor position onto the display line bases.
    always_comb begin
        if (w_val >= POS_LINE3) begin
            w_addr = BASE_LINE3 + (w_val - POS_LINE3);
        end else if (w_val >= POS_LINE2) begin
            w_addr = BASE_LINE2 + (w_val - POS_LINE2);
        end else if (w_val >= POS_LINE1) begin
            w_addr = BASE_LINE1 + (w_val - POS_LINE1);
        end else begin
            w_addr = w_val;
        end
    end

    // Decode the request type; requests without events are dropped here.
    always_comb begin
        o_job  = '{kind: JOB_BYTE, rs: 1'b0, data: w_val, extra: EXTRA_NONE};
        w_keep = 1'b1;
        unique case (i_req.req_type)
            REQ_INIT: begin
                o_job.kind = JOB_INIT;
            end
            REQ_CMD: begin
                o_job.rs = 1'b0;
            end
            REQ_DATA: begin
                o_job.rs = 1'b1;
            end
            REQ_POS: begin
                o_job.data = CMD_SET_DDRAM | {1'b0, w_addr[6:0]};
                w_keep     = (w_val < POS_LIMIT);
            end
            REQ_CLEAR: begin
                o_job.data  = CMD_CLEAR;
                o_job.extra = EXTRA_CLEAR;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_push = i_accept & w_keep;

endmodule

/* rtl/core/lcdns_fifo.sv */
`timescale 1ns / 1ps
// Short job queue between the front end and the event sequencer.
// Depends on lcdns_pkg.
module lcdns_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lcdns_pkg::t_job i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output lcdns_pkg::t_job o_head
);
    import lcdns_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/lcdns_back.sv */
`timescale 1ns / 1ps
// Back end: steps through the nibbles and enable phases of a job, one event a cycle.
// Depends on lcdns_pkg.
module lcdns_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lcdns_pkg::t_cfg i_cfg,
    input  logic            i_empty,
    input  lcdns_pkg::t_job i_head,
    output logic            o_pop,
    output logic            o_evt_valid,
    output lcdns_pkg::t_evt o_evt
);
    import lcdns_pkg::*;

    logic       r_active;
    t_job       r_job;
    logic [3:0] r_idx;
    logic [1:0] r_phase;

    logic       w_power;
    logic       w_last;
    logic [3:0] w_nib;
    logic [4:0] w_extra;

    // Current event fields.
    always_comb begin
        w_power = (r_job.kind == JOB_INIT) && (r_idx == '0);
        if (r_job.kind == JOB_INIT) begin
            w_nib   = init_nibble(r_idx, i_cfg);
            w_extra = init_extra(r_idx);
            w_last  = (r_idx == INIT_LAST_IDX) && (r_phase == PH_LOW_B);
        end else begin
            w_nib   = r_idx[0] ? r_job.data[3:0] : r_job.data[7:4];
            w_extra = r_idx[0] ? r_job.extra : EXTRA_NONE;
            w_last  = (r_idx == BYTE_LAST_IDX) && (r_phase == PH_LOW_B);
        end

        o_evt.reg_select   = r_job.rs & (r_job.kind == JOB_BYTE);
        o_evt.data_nibble  = w_power ? 4'h0 : w_nib;
        o_evt.enable_level = (r_phase == PH_HIGH) && !w_power;
        if (w_power) begin
            o_evt.hold_ms = HOLD_POWER_MS;
        end else if (r_phase == PH_LOW_B) begin
            o_evt.hold_ms = HOLD_BASE_MS + {1'b0, w_extra};
        end else begin
            o_evt.hold_ms = HOLD_BASE_MS;
        end
        o_evt.last_event = w_last;
    end

    assign o_evt_valid = r_active;
    // Take the next job while the final event of the current one goes out.
    assign o_pop = !i_empty && (!r_active || w_last);

    // Job payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
    end

    // Sequencer position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
            r_phase  <= PH_LOW_A;
        end else if (o_pop) begin
            r_active <= 1'b1;
            r_idx    <= '0;
            r_phase  <= PH_LOW_A;
        end else if (r_active) begin
            if (w_last) begin
                r_active <= 1'b0;
            end else if (w_power || r_phase == PH_LOW_B) begin
                r_idx   <= r_idx + 1'b1;
                r_phase <= PH_LOW_A;
            end else begin
                r_phase <= r_phase + 1'b1;
            end
        end
    end

endmodule

/* rtl/core/char_lcd_nibble_sequencer_core.sv */
`timescale 1ns / 1ps
// Character LCD nibble sequencer top: config registers, front end, queue, back end.
// Depends on lcdns_pkg, lcdns_front, lcdns_fifo and lcdns_back.
// A taken request is queued, then popped into the back end, before its first event; its events then follow one a cycle.
// Each byte request is two nibbles, an init is the power-on wait and 12 nibbles; a 4-entry job queue lets
// requests come in back to back, and busy is high while it is full.
// Synchronous active-low reset empties the queue and restores the config defaults.
module char_lcd_nibble_sequencer_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  lcdns_pkg::t_req i_req,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [4:0]      i_cfg_data,
    output logic            o_evt_valid,
    output lcdns_pkg::t_evt o_evt
);
    import lcdns_pkg::*;

    t_cfg r_cfg;
    t_job w_job;
    t_job w_head;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{function_flags: 5'd8, control_flags: 3'd4, entry_flags: 2'd2};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FUNCTION: r_cfg.function_flags <= i_cfg_data;
                CFG_CONTROL:  r_cfg.control_flags  <= i_cfg_data[2:0];
                CFG_ENTRY:    r_cfg.entry_flags    <= i_cfg_data[1:0];
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    assign busy = w_full;

    lcdns_front u_front (
        .i_req    (i_req),
        .i_accept (start & ~busy),
        .o_push   (w_push),
        .o_job    (w_job)
    );

    lcdns_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    lcdns_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_evt_valid (o_evt_valid),
        .o_evt       (o_evt)
    );

    // A sequence runs without gaps until its last event.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt_valid && !o_evt.last_event |=> o_evt_valid)
        else $error("event sequence broke before its last event");

    // The enable pulse is framed by low events carrying the same nibble.
    a_pulse_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt_valid && o_evt.enable_level |=> o_evt_valid && !o_evt.enable_level
            && o_evt.data_nibble == $past(o_evt.data_nibble))
        else $error("enable pulse not followed by a low event on the same nibble");

    a_pulse_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt_valid && o_evt.enable_level |-> $past(o_evt_valid)
            && !$past(o_evt.enable_level) && !$past(o_evt.last_event))
        else $error("enable pulse not preceded by a low event of the same job");

    // A job only leaves the queue when something was queued.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("job popped from an empty queue");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for char_lcd_nibble_sequencer_core.
// Depends on lcdns_pkg and the core; a directed table and random requests are
// checked event by event against a behavioral model of the pin sequencer.
module testbench;
    import lcdns_pkg::*;

    // Request codes the block ignores, and the register index it does not decode.
    localparam logic [2:0] REQ_UNUSED5 = 3'd5;
    localparam logic [2:0] REQ_UNUSED6 = 3'd6;
    localparam logic [2:0] REQ_UNUSED7 = 3'd7;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS = 10;
    localparam int PHASES = 5;
    localparam int ITEMS_PER_PHASE = 58;

    typedef struct {
        t_req        req;
        bit          typed;
        int unsigned n_evt;
        t_evt        first;
    } t_row;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    t_req            i_req;
    logic            i_cfg_we;
    logic [1:0]      i_cfg_index;
    logic [4:0]      i_cfg_data;
    logic            o_evt_valid;
    t_evt            o_evt;

    // Shadow copies of the configuration registers.
    logic [4:0] shadow_fn;
    logic [2:0] shadow_ctl;
    logic [1:0] shadow_ent;

    // Pin events of one request under construction, and all events still owed.
    t_evt pin_plan_q[$];
    t_evt pin_evt_q[$];
    t_row dir_rows[$];

    int error_count;
    int evt_checked;
    int req_count;
    int init_count;
    int ignored_count;
    int setting_count;
    t_evt want;

    char_lcd_nibble_sequencer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_evt_valid (o_evt_valid),
        .o_evt       (o_evt)
    );

    // Free-running 100 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_evt mk_evt(logic rs, logic [3:0] nib, logic en, logic [5:0] hold);
        t_evt e;
        e.reg_select   = rs;
        e.data_nibble  = nib;
        e.enable_level = en;
        e.hold_ms      = hold;
        e.last_event   = 1'b0;
        return e;
    endfunction

    // One nibble is an enable pulse low, high, low; the extra delay lands on the last hold.
    function automatic void plan_nibble(logic rs, logic [3:0] nib, logic [5:0] extra);
        pin_plan_q.push_back(mk_evt(rs, nib, 1'b0, HOLD_BASE_MS));
        pin_plan_q.push_back(mk_evt(rs, nib, 1'b1, HOLD_BASE_MS));
        pin_plan_q.push_back(mk_evt(rs, nib, 1'b0, HOLD_BASE_MS + extra));
    endfunction

    function automatic void plan_byte(logic rs, logic [7:0] b, logic [5:0] extra);
        plan_nibble(rs, b[7:4], 6'd0);
        plan_nibble(rs, b[3:0], extra);
    endfunction

    // Build the pin events one request produces, under the current shadow config.
    function automatic void plan_request(t_req r);
        logic [7:0] addr;
        t_evt       e;
        pin_plan_q.delete();
        case (r.req_type)
            REQ_INIT: begin
                pin_plan_q.push_back(mk_evt(1'b0, 4'h0, 1'b0, HOLD_POWER_MS));
                plan_nibble(1'b0, 4'h3, 6'd5);
                plan_nibble(1'b0, 4'h3, 6'd5);
                plan_nibble(1'b0, 4'h3, 6'd1);
                plan_nibble(1'b0, 4'h2, 6'd5);
                plan_byte(1'b0, 8'h20 | {3'b000, shadow_fn}, 6'd5);
                plan_byte(1'b0, 8'h08 | {5'b00000, shadow_ctl}, 6'd5);
                plan_byte(1'b0, CMD_CLEAR, 6'(EXTRA_CLEAR));
                plan_byte(1'b0, 8'h04 | {6'b000000, shadow_ent}, 6'd20);
            end
            REQ_CMD:   plan_byte(1'b0, r.byte_value, 6'd0);
            REQ_DATA:  plan_byte(1'b1, r.byte_value, 6'd0);
            REQ_POS: begin
                // Linear position to display address; off the screen sends nothing.
                if (r.byte_value < POS_LIMIT) begin
                    if (r.byte_value >= POS_LINE3)
                        addr = BASE_LINE3 + (r.byte_value - POS_LINE3);
                    else if (r.byte_value >= POS_LINE2)
                        addr = BASE_LINE2 + (r.byte_value - POS_LINE2);
                    else if (r.byte_value >= POS_LINE1)
                        addr = BASE_LINE1 + (r.byte_value - POS_LINE1);
                    else
                        addr = r.byte_value;
                    plan_byte(1'b0, CMD_SET_DDRAM | {1'b0, addr[6:0]}, 6'd0);
                end
            end
            REQ_CLEAR: plan_byte(1'b0, CMD_CLEAR, 6'(EXTRA_CLEAR));
            default: ;
        endcase
        if (pin_plan_q.size() > 0) begin
            e = pin_plan_q.pop_back();
            e.last_event = 1'b1;
            pin_plan_q.push_back(e);
        end
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Event checker: every strobed event must match the oldest owed one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_evt_valid) begin
            if (pin_evt_q.size() == 0) begin
                note_error($sformatf("unexpected event rs=%0b nib=%h en=%0b hold=%0d last=%0b",
                    o_evt.reg_select, o_evt.data_nibble, o_evt.enable_level,
                    o_evt.hold_ms, o_evt.last_event));
            end else begin
                want = pin_evt_q.pop_front();
                evt_checked++;
                if (o_evt.reg_select !== want.reg_select
                        || o_evt.data_nibble !== want.data_nibble
                        || o_evt.enable_level !== want.enable_level
                        || o_evt.hold_ms !== want.hold_ms
                        || o_evt.last_event !== want.last_event)
                    note_error($sformatf({"exp rs=%0b nib=%h en=%0b hold=%0d last=%0b, ",
                        "got rs=%0b nib=%h en=%0b hold=%0d last=%0b"},
                        want.reg_select, want.data_nibble, want.enable_level, want.hold_ms,
                        want.last_event, o_evt.reg_select, o_evt.data_nibble,
                        o_evt.enable_level, o_evt.hold_ms, o_evt.last_event));
            end
        end
    end

    // Present one request and hold it until the block takes the beat.
    task automatic send_request(input t_row row);
        t_evt first_evt;
        @(negedge i_clk);
        start = 1'b1;
        i_req = row.req;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        req_count++;
        if (row.req.req_type == REQ_INIT)
            init_count++;
        plan_request(row.req);
        if (pin_plan_q.size() == 0)
            ignored_count++;
        // Rows with a typed expectation override the first predicted event.
        if (row.typed) begin
            if (row.n_evt != pin_plan_q.size())
                note_error($sformatf("type %0d value %h: %0d events typed, %0d predicted",
                    row.req.req_type, row.req.byte_value, row.n_evt, pin_plan_q.size()));
            if (row.n_evt == 0) begin
                pin_plan_q.delete();
            end else if (pin_plan_q.size() > 0) begin
                first_evt = row.first;
                first_evt.last_event = (pin_plan_q.size() == 1);
                void'(pin_plan_q.pop_front());
                pin_plan_q.push_front(first_evt);
            end
        end
        foreach (pin_plan_q[k])
            pin_evt_q.push_back(pin_plan_q[k]);
    endtask

    // Drop start for a random gap: mostly none or short, sometimes long.
    task automatic idle_gap(input bit burst);
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (burst || pick < 55)
            n = 0;
        else if (pick < 90)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(8, 60);
        repeat (n) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    // Wait until every owed event has come, then let the block settle.
    task automatic drain_block();
        @(negedge i_clk);
        start = 1'b0;
        while (pin_evt_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_FUNCTION: shadow_fn = data;
            CFG_CONTROL:  shadow_ctl = data[2:0];
            CFG_ENTRY:    shadow_ent = data[1:0];
            default: ;
        endcase
    endtask

    function automatic void add_row(logic [2:0] kind, logic [7:0] val, bit typed,
                                    int unsigned n, t_evt first);
        t_row row;
        row.req.req_type   = kind;
        row.req.byte_value = val;
        row.typed = typed;
        row.n_evt = n;
        row.first = first;
        dir_rows.push_back(row);
    endfunction

    function automatic t_row random_row();
        t_row row;
        int   pick;
        pick = $urandom_range(0, 99);
        row.typed = 1'b0;
        row.n_evt = 0;
        row.first = '0;
        row.req.byte_value = 8'($urandom_range(0, 255));
        if (pick < 10) begin
            row.req.req_type = REQ_INIT;
        end else if (pick < 30) begin
            row.req.req_type = REQ_CMD;
        end else if (pick < 55) begin
            row.req.req_type = REQ_DATA;
        end else if (pick < 80) begin
            row.req.req_type = REQ_POS;
            if ($urandom_range(0, 99) < 85)
                row.req.byte_value = 8'($urandom_range(0, 79));
            else
                row.req.byte_value = 8'($urandom_range(80, 255));
        end else if (pick < 92) begin
            row.req.req_type = REQ_CLEAR;
        end else begin
            row.req.req_type = 3'($urandom_range(5, 7));
        end
        return row;
    endfunction

    // Main sequence: reset, directed table, then random phases under several settings.
    initial begin
        t_row row;
        bit   burst;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        shadow_fn   = 5'd8;
        shadow_ctl  = 3'd4;
        shadow_ent  = 2'd2;
        error_count = 0;
        evt_checked = 0;
        req_count = 0;
        init_count = 0;
        ignored_count = 0;
        setting_count = 1;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows: extremes, every request type, line boundaries, ignored cases.
        add_row(REQ_INIT, 8'h00, 1, 37, mk_evt(1'b0, 4'h0, 1'b0, HOLD_POWER_MS));
        add_row(REQ_CMD, 8'h00, 1, 6, mk_evt(1'b0, 4'h0, 1'b0, HOLD_BASE_MS));
        add_row(REQ_CMD, 8'hFF, 0, 0, '0);
        add_row(REQ_DATA, 8'h00, 0, 0, '0);
        add_row(REQ_DATA, 8'hFF, 1, 6, mk_evt(1'b1, 4'hF, 1'b0, HOLD_BASE_MS));
        add_row(REQ_POS, 8'd0, 1, 6, mk_evt(1'b0, 4'h8, 1'b0, HOLD_BASE_MS));
        add_row(REQ_POS, 8'd19, 0, 0, '0);
        add_row(REQ_POS, 8'd20, 0, 0, '0);
        add_row(REQ_POS, 8'd39, 0, 0, '0);
        add_row(REQ_POS, 8'd40, 0, 0, '0);
        add_row(REQ_POS, 8'd59, 0, 0, '0);
        add_row(REQ_POS, 8'd60, 0, 0, '0);
        add_row(REQ_POS, 8'd79, 1, 6, mk_evt(1'b0, 4'hE, 1'b0, HOLD_BASE_MS));
        add_row(REQ_POS, 8'd80, 1, 0, '0);
        add_row(REQ_POS, 8'd255, 1, 0, '0);
        add_row(REQ_CLEAR, 8'h00, 1, 6, mk_evt(1'b0, 4'h0, 1'b0, HOLD_BASE_MS));
        add_row(REQ_CLEAR, 8'hFF, 0, 0, '0);
        add_row(REQ_UNUSED5, 8'h00, 1, 0, '0);
        add_row(REQ_UNUSED6, 8'hAA, 1, 0, '0);
        add_row(REQ_UNUSED7, 8'hFF, 1, 0, '0);
        add_row(REQ_DATA, 8'hA5, 0, 0, '0);
        add_row(REQ_CMD, 8'h5A, 0, 0, '0);
        add_row(REQ_INIT, 8'hFF, 0, 0, '0);

        foreach (dir_rows[i]) begin
            send_request(dir_rows[i]);
            idle_gap(i < 12);
        end
        drain_block();

        for (int ph = 0; ph < PHASES; ph++) begin
            // Register settings: all ones, all zeros, then random; the unused index too.
            case (ph)
                0: begin
                    write_reg(CFG_FUNCTION, 5'h1F);
                    write_reg(CFG_CONTROL, 5'h1F);
                    write_reg(CFG_ENTRY, 5'h1F);
                end
                1: begin
                    write_reg(CFG_FUNCTION, 5'h00);
                    write_reg(CFG_CONTROL, 5'h00);
                    write_reg(CFG_ENTRY, 5'h00);
                    write_reg(CFG_UNUSED, 5'h1F);
                end
                default: begin
                    write_reg(CFG_FUNCTION, 5'($urandom_range(0, 31)));
                    write_reg(CFG_CONTROL, 5'($urandom_range(0, 31)));
                    write_reg(CFG_ENTRY, 5'($urandom_range(0, 31)));
                    write_reg(CFG_UNUSED, 5'($urandom_range(0, 31)));
                end
            endcase
            setting_count++;

            // Every phase opens with an init so the new flags reach the pins.
            row = random_row();
            row.req.req_type = REQ_INIT;
            send_request(row);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // Stretches of back-to-back beats fill the job queue.
                burst = (k % 20) < 6;
                row = random_row();
                send_request(row);
                idle_gap(burst);
            end
            drain_block();
        end

        $display("Covered %0d requests (%0d init, %0d without events) under %0d settings;",
            req_count, init_count, ignored_count, setting_count);
        $display("%0d pin events checked, %0d mismatches.", evt_checked, error_count);
        if (error_count == 0 && pin_evt_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5ms;
        $display("Timeout: events still owed: %0d", pin_evt_q.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* files.f */
rtl/core/lcdns_pkg.sv
rtl/core/lcdns_front.sv
rtl/core/lcdns_fifo.sv
rtl/core/lcdns_back.sv
rtl/core/char_lcd_nibble_sequencer_core.sv
tb/testbench.sv
